FILE: src/chs_pkg.sv
package chs_pkg;

  // Fixed field widths
  localparam int KEY_W   = 64;
  localparam int COUNT_W = 6;
  localparam int HASH_W  = 32;

  // Multiplicative hash constant
  localparam logic [HASH_W-1:0] HASH_MULT = 32'd2654435769;

  // Command codes (code 3 is unused and ignored)
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
  } chs_req_t;

  typedef struct packed {
    logic               found;
    logic               inserted;
    logic               full_res;
    logic [COUNT_W-1:0] member_count;
  } chs_rsp_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_MOD,
    ST_BKT_RD,
    ST_BKT_CHK,
    ST_NODE_CHK,
    ST_FINISH
  } chs_state_t;

endpackage

FILE: src/chained_hash_set.sv
// Set of 64-bit keys in a chained hash table: one bucket memory (used bit and chain head)
// and one node memory (key, next link, end-of-chain bit), each with a registered read.
// A command transaction is taken when start is high and busy is low; exactly one
// result follows, shown on rsp for a single cycle with done high, and it cannot be held
// off, so capture it on that cycle. Add and query pass through hash multiply, hash add,
// bucket read, bucket check, one node check per chain node visited (none for an empty
// bucket) and finish; when BUCKETS is not a power of two the bucket index goes through a
// reciprocal-multiply modulo (quotient, then remainder) after the hash add. A clear sweeps
// the bucket memory, one entry per cycle, before its result; the same sweep runs right
// after reset, with busy high throughout. The unused command code returns its result on
// the next cycle. The next command may be given in the cycle that shows the result.
module chained_hash_set #(
  parameter int BUCKETS = 64,
  parameter int NODES   = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  chs_pkg::chs_req_t  req,
  output logic               busy,
  output logic               done,
  output chs_pkg::chs_rsp_t  rsp
);

  localparam int  BW       = $clog2(BUCKETS);
  localparam int  NIW      = $clog2(NODES);
  localparam int  CW       = $clog2(NODES + 1);
  localparam int  KW       = chs_pkg::KEY_W;
  localparam int  HW       = chs_pkg::HASH_W;
  localparam int  OCW      = chs_pkg::COUNT_W;
  localparam bit  BKT_POW2 = (BUCKETS == (1 << BW));
  // Quotient width and rounded-up reciprocal for the modulo
  localparam int  QW       = HW + 1 - BW;
  localparam logic [HW:0] MOD_REC =
    (HW+1)'(((64'd1 << (HW + BW)) + 64'(BUCKETS - 1)) / 64'(BUCKETS));

  typedef struct packed {
    logic           used;
    logic [NIW-1:0] head;
  } bkt_t;

  typedef struct packed {
    logic [KW-1:0]  key;
    logic [NIW-1:0] nxt;
    logic           last;
  } node_t;

  // Memories
  bkt_t  bkt_mem  [BUCKETS];
  node_t node_mem [NODES];
  bkt_t  bkt_q;
  node_t node_q;

  // Control and datapath registers
  chs_pkg::chs_state_t state, state_next;
  logic [1:0]       kind;
  logic [KW-1:0]    key;
  logic [2*HW-1:0]  p_lo;
  logic [HW-1:0]    p_hi;
  logic [HW-1:0]    hsh;
  logic [QW-1:0]    quo;
  logic             step;
  logic [BW-1:0]    bidx;
  logic [BW-1:0]    sweep;
  logic             clr_item;
  logic             bkt_used_r;
  logic [NIW-1:0]   bkt_head_r;
  logic             hit;
  logic [CW-1:0]    count;
  logic             done_next;
  chs_pkg::chs_rsp_t rsp_next;

  // Memory port controls
  logic [BW-1:0]  bkt_raddr;
  logic [BW-1:0]  bkt_waddr;
  logic           bkt_we;
  bkt_t           bkt_wdata;
  logic [NIW-1:0] node_raddr;
  logic           node_we;
  node_t          node_wdata;

  // Hash arithmetic
  logic [2*HW-1:0] mul_lo;
  logic [HW-1:0]   mul_hi;
  logic [HW-1:0]   hash_sum;
  logic [2*HW:0]   rec_prod;
  logic [QW-1:0]   quo_next;
  logic [HW-1:0]   mod_rem;
  logic            key_match;
  logic            pool_full;
  logic            do_insert;

  assign mul_lo   = (2*HW)'(key[HW-1:0]) * (2*HW)'(chs_pkg::HASH_MULT);
  assign mul_hi   = key[KW-1:HW] * chs_pkg::HASH_MULT;
  assign hash_sum = p_lo[2*HW-1:HW] + p_hi;

  // Modulo by reciprocal: quotient first, then remainder on the next cycle
  assign rec_prod = (2*HW+1)'(hsh) * (2*HW+1)'(MOD_REC);
  assign quo_next = QW'(rec_prod >> (HW + BW));
  assign mod_rem  = hsh - HW'(quo) * HW'(BUCKETS);

  assign key_match = (node_q.key == key);
  assign pool_full = (count == CW'(NODES));
  assign do_insert = (kind == chs_pkg::KIND_ADD) && !hit && !pool_full;

  assign busy = (state != chs_pkg::ST_IDLE);

  // Bucket memory
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_q <= bkt_mem[bkt_raddr];
  end

  // Node memory
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[count[NIW-1:0]] <= node_wdata;
    end
    node_q <= node_mem[node_raddr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chs_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory controls and result
  always_comb begin
    state_next = state;
    bkt_raddr  = bidx;
    bkt_waddr  = bidx;
    bkt_we     = 1'b0;
    bkt_wdata  = '{used: 1'b1, head: count[NIW-1:0]};
    node_raddr = bkt_q.head;
    node_we    = 1'b0;
    node_wdata = '{key: key, nxt: (bkt_used_r ? bkt_head_r : '0), last: !bkt_used_r};
    done_next  = 1'b0;
    rsp_next   = '{found: 1'b0, inserted: 1'b0, full_res: 1'b0,
                   member_count: OCW'(count)};
    case (state)
      chs_pkg::ST_SWEEP: begin
        bkt_we    = 1'b1;
        bkt_waddr = sweep;
        bkt_wdata = '0;
        if (sweep == BW'(BUCKETS - 1)) begin
          state_next = chs_pkg::ST_IDLE;
          if (clr_item) begin
            done_next             = 1'b1;
            rsp_next.member_count = '0;
          end
        end
      end
      chs_pkg::ST_IDLE: begin
        if (start) begin
          case (req.kind)
            chs_pkg::KIND_ADD, chs_pkg::KIND_QUERY: state_next = chs_pkg::ST_MUL;
            chs_pkg::KIND_CLEAR:                    state_next = chs_pkg::ST_SWEEP;
            default:                                done_next  = 1'b1;
          endcase
        end
      end
      chs_pkg::ST_MUL: begin
        state_next = chs_pkg::ST_ADD;
      end
      chs_pkg::ST_ADD: begin
        state_next = BKT_POW2 ? chs_pkg::ST_BKT_RD : chs_pkg::ST_MOD;
      end
      chs_pkg::ST_MOD: begin
        if (step) begin
          state_next = chs_pkg::ST_BKT_RD;
        end
      end
      chs_pkg::ST_BKT_RD: begin
        state_next = chs_pkg::ST_BKT_CHK;
      end
      chs_pkg::ST_BKT_CHK: begin
        node_raddr = bkt_q.head;
        state_next = bkt_q.used ? chs_pkg::ST_NODE_CHK : chs_pkg::ST_FINISH;
      end
      chs_pkg::ST_NODE_CHK: begin
        // follow the chain one node per cycle
        node_raddr = node_q.nxt;
        if (key_match || node_q.last) begin
          state_next = chs_pkg::ST_FINISH;
        end
      end
      chs_pkg::ST_FINISH: begin
        state_next        = chs_pkg::ST_IDLE;
        done_next         = 1'b1;
        rsp_next.found    = hit;
        rsp_next.full_res = (kind == chs_pkg::KIND_ADD) && !hit && pool_full;
        if (do_insert) begin
          bkt_we                = 1'b1;
          node_we               = 1'b1;
          rsp_next.inserted     = 1'b1;
          rsp_next.member_count = OCW'(count + CW'(1));
        end
      end
      default: begin
        state_next = chs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep    <= '0;
      count    <= '0;
      clr_item <= 1'b0;
      done     <= 1'b0;
    end else begin
      done  <= done_next;
      sweep <= (state == chs_pkg::ST_SWEEP) ? sweep + BW'(1) : '0;
      if (state == chs_pkg::ST_IDLE && start) begin
        clr_item <= (req.kind == chs_pkg::KIND_CLEAR);
      end
      if (state == chs_pkg::ST_SWEEP && clr_item) begin
        count <= '0;
      end else if (state == chs_pkg::ST_FINISH && do_insert) begin
        count <= count + CW'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    case (state)
      chs_pkg::ST_IDLE: begin
        if (start) begin
          kind <= req.kind;
          key  <= req.key;
          hit  <= 1'b0;
        end
      end
      chs_pkg::ST_MUL: begin
        p_lo <= mul_lo;
        p_hi <= mul_hi;
      end
      chs_pkg::ST_ADD: begin
        bidx <= hash_sum[BW-1:0];
        hsh  <= hash_sum;
        step <= 1'b0;
      end
      chs_pkg::ST_MOD: begin
        quo  <= quo_next;
        step <= 1'b1;
        if (step) begin
          bidx <= mod_rem[BW-1:0];
        end
      end
      chs_pkg::ST_BKT_CHK: begin
        bkt_used_r <= bkt_q.used;
        bkt_head_r <= bkt_q.head;
      end
      chs_pkg::ST_NODE_CHK: begin
        if (key_match) begin
          hit <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
